// ===== sv/gray_sobel_pixel_stream_defines.svh =====
// assertion macros for the gray sobel pixel stream
`ifndef GRAY_SOBEL_PIXEL_STREAM_DEFINES_SVH
`define GRAY_SOBEL_PIXEL_STREAM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GSP_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GSP_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gsp_pkg.sv =====
// shared constants and types of the gray sobel pixel stream
package gsp_pkg;

    localparam int IMAGE_WIDTH  = 64;
    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int IDX_W        = $clog2(BUFFER_DEPTH + IMAGE_WIDTH + 2) + 1;

    localparam int GRAY_W  = 4;
    localparam int PIX_W   = 12;
    localparam int TDATA_W = 16;
    localparam int TAP_N   = 4;
    localparam int H_W     = 7;
    localparam int SQ_W    = 2 * H_W - 2;
    localparam int SUM_W   = SQ_W + 1;
    localparam int MAG_MAX = 15;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int PEND_W  = $clog2(Q_DEPTH + 1);

    typedef logic [GRAY_W-1:0] t_gray;
    typedef logic [TAP_N-1:0][GRAY_W-1:0] t_taps;

    typedef struct packed {
        logic             first;
        logic             second;
        logic [TAP_N-1:0] ok;
    } t_tap_ctl;

endpackage

// ===== sv/gsp_ram.sv =====
// single write, dual read synchronous ram
module gsp_ram #(
    parameter int DEPTH = 16,
    parameter int DATA_W = 4,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd0;
    logic [DATA_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

// ===== sv/gsp_mag.sv =====
// sobel accumulation, squaring and saturated square root
`include "gray_sobel_pixel_stream_defines.svh"

module gsp_mag (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsp_pkg::t_tap_ctl i_ctl,
    input  gsp_pkg::t_taps    i_taps,
    output logic              o_valid,
    output gsp_pkg::t_gray    o_mag
);

    import gsp_pkg::*;

    typedef logic signed [H_W-1:0] t_h;

    t_h                      p [TAP_N];
    t_h                      n_h0, n_v0, n_h, n_v;
    t_h                      r_h0, r_v0, r_h, r_v;
    logic signed [2*H_W-1:0] hh_full, vv_full;
    logic [SQ_W-1:0]         r_hh, r_vv;
    logic [SUM_W-1:0]        sum;
    t_gray                   n_mag, r_mag;
    logic                    r_hv_v, r_sq_v, r_mag_v;

    // out-of-range or unwritten taps read as zero
    always_comb begin
        for (int i = 0; i < TAP_N; i++) begin
            p[i] = i_ctl.ok[i] ? t_h'(i_taps[i]) : '0;
        end
    end

    // top row and left centre tap
    assign n_h0 = p[2] - p[0] - p[3] - p[3];
    assign n_v0 = t_h'(0) - p[0] - p[1] - p[1] - p[2];

    // right centre tap and bottom row
    assign n_h = r_h0 + p[0] + p[0] - p[1] + p[3];
    assign n_v = r_v0 + p[1] + p[2] + p[2] + p[3];

    always_ff @(posedge i_clk) begin
        if (i_ctl.first) begin
            r_h0 <= n_h0;
            r_v0 <= n_v0;
        end
        if (i_ctl.second) begin
            r_h <= n_h;
            r_v <= n_v;
        end
    end

    always_comb begin
        hh_full = r_h * r_h;
        vv_full = r_v * r_v;
    end

    always_ff @(posedge i_clk) begin
        r_hh <= hh_full[SQ_W-1:0];
        r_vv <= vv_full[SQ_W-1:0];
    end

    assign sum = {1'b0, r_hh} + {1'b0, r_vv};

    always_comb begin
        n_mag = '0;
        for (int k = 1; k <= MAG_MAX; k++) begin
            if (sum >= SUM_W'(k * k)) begin
                n_mag = GRAY_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv_v  <= 1'b0;
            r_sq_v  <= 1'b0;
            r_mag_v <= 1'b0;
        end else begin
            r_hv_v  <= i_ctl.second;
            r_sq_v  <= r_hv_v;
            r_mag_v <= r_sq_v;
        end
    end

    assign o_valid = r_mag_v;
    assign o_mag   = r_mag;

    `GSP_CHECK_NEXT(a_second_follows, i_ctl.first, i_ctl.second, "bottom row read missing")
    `GSP_CHECK(a_second_paired, i_ctl.second, $past(i_ctl.first), "bottom row without top row")

endmodule

// ===== sv/gsp_out_q.sv =====
// result queue in front of the output channel
`include "gray_sobel_pixel_stream_defines.svh"

module gsp_out_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gsp_pkg::t_gray i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output gsp_pkg::t_gray o_data
);

    import gsp_pkg::*;

    t_gray             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [PEND_W-1:0] r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `GSP_CHECK(a_no_overflow, i_push, r_count != PEND_W'(Q_DEPTH), "result queue overflow")

endmodule

// ===== sv/gray_sobel_pixel_stream.sv =====
// top level: gray conversion, ring store, window reads and result output
//
//  channel  | dir | tdata bits             | accepted when
//  s_axis   | in  | 11:0 pixel_rgb         | s_axis_tvalid && s_axis_tready
//  m_axis   | out | 11:0 edge_rgb          | m_axis_tvalid && m_axis_tready
//
//  at the input, the idle state does the gray write and top-row reads, and the tail
//  state the bottom-row reads; two dual-port ram copies give four taps a cycle
//  results pass the ram read, sum, square and root registers, then the result queue
//  a four-item result queue lets input run while the output stalls; the input stalls
//  once four items are outstanding
//  reset clears the write pointer; a wrap flag marks the store as fully written,
//  so no clearing pass is needed
`include "gray_sobel_pixel_stream_defines.svh"

module gray_sobel_pixel_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [gsp_pkg::TDATA_W-1:0]    s_axis_tdata,   // 11:0 pixel_rgb
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gsp_pkg::TDATA_W-1:0]    m_axis_tdata    // 11:0 edge_rgb
);

    import gsp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TAIL = 2'b10
    } t_state;

    typedef logic signed [IDX_W-1:0] t_idx;

    localparam logic SET_TOP = 1'b0;
    localparam logic SET_BOT = 1'b1;

    // row offsets of the four taps read in each cycle
    localparam t_idx TAP_OFS [2][TAP_N] = '{
        '{t_idx'(-IMAGE_WIDTH - 1), t_idx'(-IMAGE_WIDTH), t_idx'(1 - IMAGE_WIDTH), t_idx'(-1)},
        '{t_idx'(1), t_idx'(IMAGE_WIDTH - 1), t_idx'(IMAGE_WIDTH), t_idx'(IMAGE_WIDTH + 1)}
    };

    // truncated channel weights 0.3, 0.59, 0.11
    localparam t_gray RED_LUT [16] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4
    };
    localparam t_gray GRN_LUT [16] = '{
        4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4,
        4'd4, 4'd5, 4'd5, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8
    };
    localparam t_gray BLU_LUT [16] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_wp, n_wp;
    logic              r_wrapped, n_wrapped;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_first, r_second;
    logic [TAP_N-1:0]  r_ok;

    logic              acc, deliver, set_sel;
    t_gray             gray, q_data, mag;
    logic              mag_v;
    t_idx              base;
    t_idx              tap_idx [TAP_N];
    logic [TAP_N-1:0]  tap_ok;
    logic [ADDR_W-1:0] raddr [TAP_N];
    t_taps             rdata;
    t_tap_ctl          tap_ctl;

    assign s_axis_tready = (r_state == S_IDLE) && (r_pend < PEND_W'(Q_DEPTH));
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign deliver       = m_axis_tvalid && m_axis_tready;

    assign gray = RED_LUT[s_axis_tdata[11:8]] + GRN_LUT[s_axis_tdata[7:4]]
                + BLU_LUT[s_axis_tdata[3:0]];

    assign base    = t_idx'(r_wp);
    assign set_sel = (r_state == S_TAIL) ? SET_BOT : SET_TOP;

    always_comb begin
        for (int i = 0; i < TAP_N; i++) begin
            tap_idx[i] = base + TAP_OFS[set_sel][i];
            tap_ok[i]  = (tap_idx[i] >= t_idx'(0))
                      && (tap_idx[i] < t_idx'(BUFFER_DEPTH))
                      && (r_wrapped || (tap_idx[i] < base));
            raddr[i]   = tap_idx[i][ADDR_W-1:0];
        end
    end

    gsp_ram #(.DEPTH(BUFFER_DEPTH), .DATA_W(GRAY_W)) u_ram_lo (
        .i_clk    (i_clk),
        .i_we     (acc),
        .i_waddr  (r_wp),
        .i_wdata  (gray),
        .i_raddr0 (raddr[0]),
        .i_raddr1 (raddr[1]),
        .o_rdata0 (rdata[0]),
        .o_rdata1 (rdata[1])
    );

    gsp_ram #(.DEPTH(BUFFER_DEPTH), .DATA_W(GRAY_W)) u_ram_hi (
        .i_clk    (i_clk),
        .i_we     (acc),
        .i_waddr  (r_wp),
        .i_wdata  (gray),
        .i_raddr0 (raddr[2]),
        .i_raddr1 (raddr[3]),
        .o_rdata0 (rdata[2]),
        .o_rdata1 (rdata[3])
    );

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_wrapped = r_wrapped;
        n_pend    = r_pend;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_IDLE;
                if (r_wp == ADDR_W'(BUFFER_DEPTH - 1)) begin
                    n_wp      = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_wp = r_wp + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (acc && !deliver) begin
            n_pend = r_pend + 1'b1;
        end else if (!acc && deliver) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_pend    <= '0;
            r_first   <= 1'b0;
            r_second  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
            r_pend    <= n_pend;
            r_first   <= acc;
            r_second  <= (r_state == S_TAIL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= tap_ok;
    end

    assign tap_ctl = '{first: r_first, second: r_second, ok: r_ok};

    gsp_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tap_ctl),
        .i_taps  (rdata),
        .o_valid (mag_v),
        .o_mag   (mag)
    );

    gsp_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mag_v),
        .i_data  (mag),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_data)
    );

    assign m_axis_tdata = TDATA_W'({q_data, q_data, q_data});

    `GSP_CHECK(a_pend_bound, 1'b1, r_pend <= PEND_W'(Q_DEPTH), "too many items outstanding")
    `GSP_CHECK(a_out_pending, m_axis_tvalid, r_pend != '0, "result without a pending item")
    `GSP_CHECK_NEXT(a_wp_step, r_state == S_TAIL, r_wp != $past(r_wp), "write pointer stuck")

endmodule
